@@ hw/rtl/jpp_pkg.sv @@
package jpp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DepthW  = 6;
  localparam int unsigned IndentW = 6;

  localparam int unsigned CmdQDepth = 4;
  localparam int unsigned CmdQPtrW  = $clog2(CmdQDepth);
  localparam int unsigned CmdQCntW  = $clog2(CmdQDepth + 1);

  localparam logic [CharW-1:0] ChLBrace  = 8'h7B;
  localparam logic [CharW-1:0] ChLBrack  = 8'h5B;
  localparam logic [CharW-1:0] ChRBrace  = 8'h7D;
  localparam logic [CharW-1:0] ChRBrack  = 8'h5D;
  localparam logic [CharW-1:0] ChComma   = 8'h2C;
  localparam logic [CharW-1:0] ChColon   = 8'h3A;
  localparam logic [CharW-1:0] ChQuote   = 8'h22;
  localparam logic [CharW-1:0] ChBslash  = 8'h5C;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;

  // Shape of the output run that one input byte turns into.
  typedef enum logic [2:0] {
    CMD_ONE,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_COMMA,
    CMD_COLON
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_NL,
    PH_IND,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CharW-1:0]   ch;
    logic [IndentW-1:0] indent;
    logic               ovf;
  } cmd_t;

endpackage

@@ hw/rtl/jpp_if.sv @@
interface jpp_in_if;
  logic                        valid;
  logic                        ready;
  logic [jpp_pkg::CharW-1:0]   in_char;
  logic                        start_of_text;

  modport source (output valid, in_char, start_of_text, input ready);
  modport sink   (input valid, in_char, start_of_text, output ready);
endinterface

interface jpp_out_if;
  logic                        valid;
  logic                        ready;
  logic [jpp_pkg::CharW-1:0]   out_char;
  logic                        last_of_run;
  logic                        depth_overflow;

  modport source (output valid, out_char, last_of_run, depth_overflow, input ready);
  modport sink   (input valid, out_char, last_of_run, depth_overflow, output ready);
endinterface

@@ hw/rtl/json_pretty_printer_top.sv @@
// Channel   Dir  Payload                                        Beat
// in_if     in   in_char[7:0], start_of_text                    one text byte
// out_if    out  out_char[7:0], last_of_run, depth_overflow     one output byte
//
// Each input byte becomes 0 to 64 output beats, one beat per cycle at most.
// The front takes one byte per cycle while the 4-entry command queue has room.
// The back end sets the rate: a run of up to 2 + 2*depth beats holds it from the next
// command, and its output register lets it run ahead of a stalled sink by one beat.
// Reset clears the string, escape and depth state, the queue and the output valid.
module json_pretty_printer_top #(
  parameter int unsigned MAX_DEPTH = 31
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jpp_in_if.sink    in_if,
  jpp_out_if.source out_if
);
  import jpp_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  jpp_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_o      (in_if.ready),
    .in_char_i       (in_if.in_char),
    .start_of_text_i (in_if.start_of_text),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  jpp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  jpp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_ready_o      (q_ready),
    .cmd_i            (q_cmd),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_char_o       (out_if.out_char),
    .last_of_run_o    (out_if.last_of_run),
    .depth_overflow_o (out_if.depth_overflow)
  );

endmodule

@@ hw/rtl/jpp_front.sv @@
module jpp_front #(
  parameter int unsigned MAX_DEPTH = 31
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jpp_pkg::CharW-1:0] in_char_i,
  input  logic                      start_of_text_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_ready_i,
  output jpp_pkg::cmd_t             cmd_o
);
  import jpp_pkg::*;

  localparam logic signed [DepthW-1:0] MaxDep = DepthW'(MAX_DEPTH);
  localparam logic signed [DepthW-1:0] MinDep = -MaxDep;

  logic                      str_q, str_d;
  logic                      esc_q, esc_d;
  logic signed [DepthW-1:0]  dep_q, dep_d;

  logic                      str_c, esc_c;
  logic signed [DepthW-1:0]  dep_c;
  logic                      drop;
  logic                      accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = cmd_ready_i;

  always_comb begin
    // A start flag clears the state before this byte is looked at.
    str_c = start_of_text_i ? 1'b0 : str_q;
    esc_c = start_of_text_i ? 1'b0 : esc_q;
    dep_c = start_of_text_i ? '0 : dep_q;

    str_d       = str_c;
    esc_d       = esc_c;
    dep_d       = dep_c;
    drop        = 1'b0;
    cmd_o.kind  = CMD_ONE;
    cmd_o.ch    = in_char_i;
    cmd_o.ovf   = 1'b0;

    priority if (esc_c) begin
      esc_d = 1'b0;
    end else if (in_char_i == ChBslash && str_c) begin
      esc_d = 1'b1;
    end else if (in_char_i == ChQuote) begin
      str_d = ~str_c;
    end else if (str_c) begin
      cmd_o.kind = CMD_ONE;
    end else begin
      unique case (in_char_i)
        ChLBrace, ChLBrack: begin
          cmd_o.kind = CMD_OPEN;
          if (dep_c >= MaxDep) begin
            dep_d     = MaxDep;
            cmd_o.ovf = 1'b1;
          end else begin
            dep_d = dep_c + DepthW'(1);
          end
        end
        ChRBrace, ChRBrack: begin
          cmd_o.kind = CMD_CLOSE;
          if (dep_c <= MinDep) begin
            dep_d     = MinDep;
            cmd_o.ovf = 1'b1;
          end else begin
            dep_d = dep_c - DepthW'(1);
          end
        end
        ChComma:                     cmd_o.kind = CMD_COMMA;
        ChColon:                     cmd_o.kind = CMD_COLON;
        ChSpace, ChTab, ChNewline:   drop = 1'b1;
        default:                     cmd_o.kind = CMD_ONE;
      endcase
    end

    // Two spaces for each positive level of the updated depth.
    cmd_o.indent = (dep_d > 0) ? {dep_d[DepthW-2:0], 1'b0} : '0;
  end

  assign cmd_valid_o = in_valid_i && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q <= 1'b0;
      esc_q <= 1'b0;
      dep_q <= '0;
    end else if (accept) begin
      str_q <= str_d;
      esc_q <= esc_d;
      dep_q <= dep_d;
    end
  end

endmodule

@@ hw/rtl/jpp_fifo.sv @@
module jpp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  jpp_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output jpp_pkg::cmd_t pop_data_o
);
  import jpp_pkg::*;

  cmd_t                mem_q [CmdQDepth];
  logic [CmdQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdQCntW-1:0] cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CmdQCntW'(CmdQDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + CmdQPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + CmdQPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CmdQCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CmdQCntW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/jpp_back.sv @@
module jpp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  jpp_pkg::cmd_t             cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [jpp_pkg::CharW-1:0] out_char_o,
  output logic                      last_of_run_o,
  output logic                      depth_overflow_o
);
  import jpp_pkg::*;

  logic                busy_q, busy_d;
  cmd_t                cmd_q, cmd_d;
  phase_e              ph_q, ph_d;
  logic [IndentW-1:0]  cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    out_char_q;
  logic                last_q, ovf_q;

  logic                produce;
  logic                done;
  logic [CharW-1:0]    byte_c;
  phase_e              ph_nx;
  logic [IndentW-1:0]  cnt_nx;
  logic                load;

  assign produce = busy_q && (!out_valid_q || out_ready_i);

  // Byte for the current phase and where the run goes next.
  always_comb begin
    byte_c = cmd_q.ch;
    ph_nx  = ph_q;
    cnt_nx = cnt_q;
    done   = 1'b0;
    unique case (ph_q)
      PH_HEAD: begin
        byte_c = cmd_q.ch;
        unique case (cmd_q.kind)
          CMD_OPEN, CMD_COMMA: ph_nx = PH_NL;
          CMD_COLON:           ph_nx = PH_TAIL;
          default:             done  = 1'b1;
        endcase
      end
      PH_NL: begin
        byte_c = ChNewline;
        if (cnt_q != '0) begin
          ph_nx = PH_IND;
        end else if (cmd_q.kind == CMD_CLOSE) begin
          ph_nx = PH_TAIL;
        end else begin
          done = 1'b1;
        end
      end
      PH_IND: begin
        byte_c = ChSpace;
        cnt_nx = cnt_q - IndentW'(1);
        if (cnt_q == IndentW'(1)) begin
          if (cmd_q.kind == CMD_CLOSE) begin
            ph_nx = PH_TAIL;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        byte_c = (cmd_q.kind == CMD_CLOSE) ? cmd_q.ch : ChSpace;
        done   = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // A new command is taken when idle or in the cycle the current run ends.
  assign load        = cmd_valid_i && (!busy_q || (produce && done));
  assign cmd_ready_o = !busy_q || (produce && done);

  always_comb begin
    busy_d = busy_q;
    cmd_d  = cmd_q;
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      ph_d   = (cmd_i.kind == CMD_CLOSE) ? PH_NL : PH_HEAD;
      cnt_d  = cmd_i.indent;
    end else if (produce) begin
      busy_d = !done;
      ph_d   = ph_nx;
      cnt_d  = cnt_nx;
    end

    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ph_q        <= PH_HEAD;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cnt_q <= cnt_d;
    if (produce) begin
      out_char_q <= byte_c;
      last_q     <= done;
      ovf_q      <= cmd_q.ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign last_of_run_o    = last_q;
  assign depth_overflow_o = ovf_q;

endmodule

@@ hw/rtl/jpp_checker.sv @@
module jpp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [jpp_pkg::CharW-1:0] out_char_i,
  input logic                      last_of_run_i,
  input logic                      depth_overflow_i
);
  import jpp_pkg::*;

  // Nothing can be on the output in the first cycle out of reset.
  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_char_i) && $stable(last_of_run_i) && $stable(depth_overflow_i))
    else $error("output payload changed while stalled");

  // A saturated open ends in indentation, a saturated close in its bracket.
  a_ovf_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && depth_overflow_i && last_of_run_i |->
      (out_char_i == ChSpace) || (out_char_i == ChRBrace) || (out_char_i == ChRBrack))
    else $error("overflow run ends on an unexpected byte");

endmodule

bind json_pretty_printer_top jpp_checker u_jpp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_char_i       (out_if.out_char),
  .last_of_run_i    (out_if.last_of_run),
  .depth_overflow_i (out_if.depth_overflow)
);

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jpp_pkg::*;

  localparam int MaxDepth   = 31;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int NumItems   = 220;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    logic             ovf;
  } text_beat_t;

  // Tracks the formatter state and holds the output text still owed by the block.
  class text_scoreboard;
    text_beat_t       expected_text[$];
    logic [CharW-1:0] run_q[$];
    bit               in_str;
    bit               esc;
    int               depth;
    int unsigned      errors;

    function void add_byte(logic [CharW-1:0] c);
      run_q.insert(run_q.size(), c);
    endfunction

    function void push_indent();
      int lvl;
      lvl = (depth > 0) ? depth : 0;
      for (int n = 0; n < 2 * lvl; n++) add_byte(ChSpace);
    endfunction

    // Returns how many output beats the byte produces.
    function int note_input(logic [CharW-1:0] ch, logic sot);
      logic       ovf;
      text_beat_t beat;
      ovf = 1'b0;
      run_q.delete();
      if (sot) begin
        in_str = 0;
        esc    = 0;
        depth  = 0;
      end
      if (esc) begin
        add_byte(ch);
        esc = 0;
      end else if (ch == ChBslash && in_str) begin
        add_byte(ch);
        esc = 1;
      end else if (ch == ChQuote) begin
        in_str = !in_str;
        add_byte(ch);
      end else if (in_str) begin
        add_byte(ch);
      end else begin
        case (ch)
          ChLBrace, ChLBrack: begin
            add_byte(ch);
            add_byte(ChNewline);
            if (depth >= MaxDepth) begin
              depth = MaxDepth;
              ovf   = 1'b1;
            end else begin
              depth++;
            end
            push_indent();
          end
          ChRBrace, ChRBrack: begin
            add_byte(ChNewline);
            if (depth <= -MaxDepth) begin
              depth = -MaxDepth;
              ovf   = 1'b1;
            end else begin
              depth--;
            end
            push_indent();
            add_byte(ch);
          end
          ChComma: begin
            add_byte(ch);
            add_byte(ChNewline);
            push_indent();
          end
          ChColon: begin
            add_byte(ch);
            add_byte(ChSpace);
          end
          ChSpace, ChTab, ChNewline: ;
          default: add_byte(ch);
        endcase
      end
      foreach (run_q[i]) begin
        beat.ch   = run_q[i];
        beat.last = (i == run_q.size() - 1);
        beat.ovf  = ovf;
        expected_text.insert(expected_text.size(), beat);
      end
      return run_q.size();
    endfunction

    function void check_beat(logic [CharW-1:0] ch, logic last, logic ovf);
      text_beat_t exp_beat;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected beat out_char=%h last=%b ovf=%b", $time, ch, last, ovf);
        errors++;
        return;
      end
      exp_beat = expected_text.pop_front();
      if (ch !== exp_beat.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, exp_beat.ch, ch);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, exp_beat.last, last);
        errors++;
      end
      if (ovf !== exp_beat.ovf) begin
        $display("%0t: depth_overflow expected %b actual %b", $time, exp_beat.ovf, ovf);
        errors++;
      end
    endfunction

    function int waiting();
      return expected_text.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  jpp_in_if  in_if ();
  jpp_out_if out_if ();

  json_pretty_printer_top #(
    .MAX_DEPTH(MaxDepth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  text_scoreboard   sb = new();
  logic [CharW-1:0] text_q[$];
  int               burst_left;
  int               n_sent;
  int               cycles;
  bit               held_off;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_beat(out_if.out_char, out_if.last_of_run, out_if.depth_overflow);
    end
  end

  // Sink pacing: stretches of full rate, random stalls and a fixed stutter, plus
  // one long hold-off early on that backs the block up into its input.
  initial begin
    int mode;
    int len;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && n_sent >= 40) begin
        @(negedge clk);
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        held_off = 1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 120);
      for (int c = 0; c < len; c++) begin
        @(negedge clk);
        case (mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = 1'($urandom_range(0, 1));
          2: out_if.ready = ($urandom_range(0, 3) == 0);
          default: out_if.ready = (c % 3 != 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [CharW-1:0] ch, input logic sot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid         = 1'b1;
    in_if.in_char       = ch;
    in_if.start_of_text = sot;
    do @(posedge clk); while (!in_if.ready);
    n_sent++;
    void'(sb.note_input(ch, sot));
    @(negedge clk);
  endtask

  task automatic send_text(input logic first_sot);
    foreach (text_q[i]) send_byte(text_q[i], (i == 0) ? first_sot : 1'b0);
    text_q.delete();
  endtask

  function automatic void append_char(logic [CharW-1:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void add_gap();
    int r;
    r = $urandom_range(0, 14);
    if (r == 0) append_char(ChSpace);
    else if (r == 1) append_char(ChTab);
    else if (r == 2) append_char(ChNewline);
  endfunction

  function automatic void add_string();
    int n;
    int r;
    logic [CharW-1:0] c;
    append_char(ChQuote);
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        // The escaped byte may be any nonzero byte, a quote included.
        append_char(ChBslash);
        append_char(CharW'($urandom_range(1, 255)));
      end else if (r == 1) begin
        append_char(CharW'($urandom_range(128, 255)));
      end else begin
        c = CharW'($urandom_range(32, 126));
        if (c == ChQuote || c == ChBslash) c = "_";
        append_char(c);
      end
    end
    append_char(ChQuote);
  endfunction

  function automatic void add_value(int lvl);
    int    kind;
    int    n;
    string s;
    string digits;
    digits = "0123456789.-e";
    kind = (lvl >= 3) ? $urandom_range(2, 4) : $urandom_range(0, 4);
    add_gap();
    case (kind)
      0: begin
        append_char(ChLBrace);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) append_char(ChComma);
          add_gap();
          add_string();
          add_gap();
          append_char(ChColon);
          add_value(lvl + 1);
        end
        append_char(ChRBrace);
      end
      1: begin
        append_char(ChLBrack);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if (i > 0) append_char(ChComma);
          add_value(lvl + 1);
        end
        append_char(ChRBrack);
      end
      2: add_string();
      3: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) append_char(digits[$urandom_range(0, 12)]);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: s = "true";
          1: s = "false";
          default: s = "null";
        endcase
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
      end
    endcase
    add_gap();
  endfunction

  initial begin
    int               choice;
    int               pos;
    logic [CharW-1:0] junk;

    in_if.valid         = 1'b0;
    in_if.in_char       = '0;
    in_if.start_of_text = 1'b0;
    rst_n               = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: every token class, escapes, whitespace in and out of strings,
    // backslash outside a string, zero and all-ones bytes, negative depth, and a
    // start flag that cuts an open string short.
    send_byte(ChLBrace, 1'b1);
    send_byte(ChQuote, 1'b0);
    send_byte("k", 1'b0);
    send_byte(ChBslash, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte(ChColon, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(ChLBrack, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ChComma, 1'b0);
    send_byte(ChBslash, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChNewline, 1'b0);
    send_byte(ChRBrack, 1'b0);
    send_byte(ChRBrace, 1'b0);
    send_byte(ChRBrace, 1'b0);
    send_byte(ChComma, 1'b0);
    send_byte(ChLBrace, 1'b0);
    send_byte(ChQuote, 1'b0);
    send_byte("x", 1'b0);
    send_byte(ChRBrace, 1'b1);

    // Climb past the upper depth limit and come all the way back down.
    send_byte(ChLBrack, 1'b1);
    for (int i = 0; i < MaxDepth + 2; i++) begin
      send_byte($urandom_range(0, 1) ? ChLBrace : ChLBrack, 1'b0);
    end
    for (int i = 0; i < MaxDepth + 2; i++) begin
      send_byte($urandom_range(0, 1) ? ChRBrace : ChRBrack, 1'b0);
    end

    // Fall past the lower limit; indentation stays empty below zero.
    send_byte(ChRBrace, 1'b1);
    for (int i = 0; i < MaxDepth + 2; i++) begin
      send_byte($urandom_range(0, 1) ? ChRBrace : ChRBrack, 1'b0);
      if ($urandom_range(0, 7) == 0) send_byte(ChComma, 1'b0);
    end

    while (n_sent < NumItems) begin
      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
        add_value(0);
        send_text($urandom_range(0, 4) != 0);
      end else if (choice <= 7) begin
        // Malformed document: cut short, or with a stray token dropped in.
        add_value(0);
        if ($urandom_range(0, 1) && text_q.size() > 1) begin
          pos = $urandom_range(1, text_q.size() - 1);
          text_q = text_q[0:pos-1];
        end else begin
          case ($urandom_range(0, 6))
            0: junk = ChLBrace;
            1: junk = ChRBrack;
            2: junk = ChQuote;
            3: junk = ChBslash;
            4: junk = ChComma;
            5: junk = ChColon;
            default: junk = CharW'($urandom_range(0, 255));
          endcase
          text_q.insert($urandom_range(0, text_q.size()), junk);
        end
        send_text(1'($urandom_range(0, 1)));
      end else if (choice == 8) begin
        for (int i = $urandom_range(4, 12); i > 0; i--) begin
          send_byte(CharW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end else begin
        for (int i = $urandom_range(3, 10); i > 0; i--) begin
          case ($urandom_range(0, 3))
            0: append_char(ChLBrace);
            1: append_char(ChLBrack);
            2: append_char(ChRBrace);
            default: append_char(ChComma);
          endcase
        end
        send_text(1'($urandom_range(0, 1)));
      end
    end

    in_if.valid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
